// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/pcrg_pkg.sv
`default_nettype none
package pcrg_pkg;

    typedef logic [2:0][31:0] vec3_t;

    localparam logic [31:0] F_HALF  = 32'h3F000000;
    localparam logic [31:0] F_NHALF = 32'hBF000000;
    localparam logic [31:0] F_ONE   = 32'h3F800000;
    localparam logic [31:0] F_QNAN  = 32'h7FC00000;

    // quotient bits (24 mantissa + guard) and root bits
    localparam int DIV_STEPS  = 25;
    localparam int SQRT_STEPS = 25;

    typedef enum logic [2:0] {
        REG_ROT_M00_M01      = 3'd0,
        REG_ROT_M02_M10      = 3'd1,
        REG_ROT_M11_M12      = 3'd2,
        REG_ROT_M20_M21      = 3'd3,
        REG_ROT_M22          = 3'd4,
        REG_ASPECT_AND_SCALE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] rot_m00_m01;
        logic [63:0] rot_m02_m10;
        logic [63:0] rot_m11_m12;
        logic [63:0] rot_m20_m21;
        logic [31:0] rot_m22;
        logic [63:0] aspect_and_scale;
    } cfg_t;

    typedef struct packed {
        logic              s;
        logic signed [9:0] e;
        logic [23:0]       m;
    } unp_t;

    // divider lane state
    typedef struct packed {
        logic        sp;
        logic [31:0] spv;
        logic        s;
        logic [10:0] e;
        logic [23:0] mb;
        logic [25:0] rem;
        logic [24:0] q;
    } div_lane_t;

    // square root state
    typedef struct packed {
        logic        sp;
        logic [31:0] spv;
        logic [9:0]  re;
        logic [49:0] mw;
        logic [24:0] root;
        logic [26:0] rem;
    } sqrt_lane_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] x);
        return is_nan(x) ? F_QNAN : x;
    endfunction

    // leading zeros, input assumed nonzero
    function automatic logic [4:0] lzc32(input logic [31:0] x);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 5'(31 - i);
        end
        return n;
    endfunction

    // unpack with subnormals normalized: value = m * 2^(e-150)
    function automatic unp_t unpack_norm(input logic [31:0] x);
        unp_t u;
        logic [4:0] lz;
        u.s = x[31];
        if (x[30:23] == 8'd0) begin
            lz  = lzc32({1'b0, x[22:0], 8'hFF});
            u.m = 24'({1'b0, x[22:0]} << lz);
            u.e = 10'sd1 - $signed({5'd0, lz});
        end else begin
            u.m = {1'b1, x[22:0]};
            u.e = $signed({2'b0, x[30:23]});
        end
        return u;
    endfunction

    // round to nearest even and pack; handles subnormal and overflow
    function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [23:0] m, input logic g,
                                               input logic st);
        logic [48:0] w;
        logic [4:0]  sh;
        logic [23:0] m2;
        logic        g2;
        logic        st2;
        logic        inc;
        logic [7:0]  e8;
        logic [31:0] r;
        if (e >= 11'sd255) begin
            r = {s, 8'hFF, 23'd0};
        end else begin
            if (e < 11'sd1) begin
                sh  = (e < -11'sd25) ? 5'd26 : 5'(11'sd1 - e);
                w   = {m, g, 24'd0} >> sh;
                m2  = w[48:25];
                g2  = w[24];
                st2 = st | (|w[23:0]);
                e8  = 8'd0;
            end else begin
                m2  = m;
                g2  = g;
                st2 = st;
                e8  = e[7:0];
            end
            inc = g2 & (st2 | m2[0]);
            r   = {s, e8, m2[22:0]} + {31'd0, inc};
        end
        return r;
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hx;
        logic [31:0] lx;
        logic [9:0]  el;
        logic [9:0]  es;
        logic [23:0] ml;
        logic [23:0] ms;
        logic [7:0]  d;
        logic [53:0] wide;
        logic [26:0] msx;
        logic [27:0] sum;
        logic [26:0] r;
        logic [4:0]  lz;
        logic        st;
        logic [10:0] e;
        logic [31:0] res;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
            res = F_QNAN;
        end else if (is_inf(a)) begin
            res = a;
        end else if (is_inf(b)) begin
            res = b;
        end else if (is_zero(a) && is_zero(b)) begin
            res = {a[31] & b[31], 31'd0};
        end else if (is_zero(a)) begin
            res = b;
        end else if (is_zero(b)) begin
            res = a;
        end else begin
            if (b[30:0] > a[30:0]) begin
                hx = b;
                lx = a;
            end else begin
                hx = a;
                lx = b;
            end
            el   = (hx[30:23] == 8'd0) ? 10'd1 : {2'b0, hx[30:23]};
            es   = (lx[30:23] == 8'd0) ? 10'd1 : {2'b0, lx[30:23]};
            ml   = {hx[30:23] != 8'd0, hx[22:0]};
            ms   = {lx[30:23] != 8'd0, lx[22:0]};
            d    = 8'(el - es);
            wide = {ms, 3'b0, 27'd0} >> ((d > 8'd27) ? 8'd27 : d);
            msx  = {wide[53:28], wide[27] | (|wide[26:0])};
            if (hx[31] == lx[31]) sum = {1'b0, ml, 3'b0} + {1'b0, msx};
            else                  sum = {1'b0, ml, 3'b0} - {1'b0, msx};
            if (sum == 28'd0) begin
                res = 32'd0;
            end else begin
                if (sum[27]) begin
                    r  = sum[27:1];
                    st = sum[0];
                    e  = {1'b0, el} + 11'd1;
                end else begin
                    lz = lzc32({sum[26:0], 5'h1F});
                    r  = sum[26:0] << lz;
                    st = 1'b0;
                    e  = {1'b0, el} - {6'd0, lz};
                end
                res = round_pack(hx[31], e, r[26:3], r[2], st | r[1] | r[0]);
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        unp_t        ua;
        unp_t        ub;
        logic        s;
        logic [47:0] p;
        logic [10:0] e;
        logic [31:0] res;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
        begin
            res = F_QNAN;
        end else if (is_inf(a) || is_inf(b)) begin
            res = {s, 8'hFF, 23'd0};
        end else if (is_zero(a) || is_zero(b)) begin
            res = {s, 31'd0};
        end else begin
            ua = unpack_norm(a);
            ub = unpack_norm(b);
            p  = ua.m * ub.m;
            e  = {ua.e[9], ua.e} + {ub.e[9], ub.e} - 11'd127;
            if (p[47]) res = round_pack(s, e + 11'd1, p[47:24], p[23], |p[22:0]);
            else       res = round_pack(s, e, p[46:23], p[22], |p[21:0]);
        end
        return res;
    endfunction

    function automatic div_lane_t div_prep(input logic [31:0] a, input logic [31:0] b);
        div_lane_t x;
        unp_t      ua;
        unp_t      ub;
        x    = '0;
        x.s  = a[31] ^ b[31];
        x.sp = 1'b1;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b)))
        begin
            x.spv = F_QNAN;
        end else if (is_inf(a) || is_zero(b)) begin
            x.spv = {x.s, 8'hFF, 23'd0};
        end else if (is_zero(a) || is_inf(b)) begin
            x.spv = {x.s, 31'd0};
        end else begin
            x.sp = 1'b0;
            ua   = unpack_norm(a);
            ub   = unpack_norm(b);
            x.mb = ub.m;
            x.e  = {ua.e[9], ua.e} - {ub.e[9], ub.e} + 11'd127;
            if (ua.m < ub.m) begin
                x.rem = {1'b0, ua.m, 1'b0};
                x.e   = x.e - 11'd1;
            end else begin
                x.rem = {2'b0, ua.m};
            end
        end
        return x;
    endfunction

    // one restoring quotient bit
    function automatic div_lane_t div_step(input div_lane_t x);
        div_lane_t y;
        logic      ge;
        logic [25:0] r;
        y     = x;
        ge    = x.rem >= {2'b0, x.mb};
        r     = ge ? (x.rem - {2'b0, x.mb}) : x.rem;
        y.rem = {r[24:0], 1'b0};
        y.q   = {x.q[23:0], ge};
        return y;
    endfunction

    function automatic logic [31:0] div_final(input div_lane_t x);
        return x.sp ? x.spv : round_pack(x.s, $signed(x.e), x.q[24:1], x.q[0], x.rem != 26'd0);
    endfunction

    function automatic sqrt_lane_t sqrt_prep(input logic [31:0] a);
        sqrt_lane_t x;
        unp_t       u;
        logic [9:0] e;
        logic [9:0] t;
        logic [24:0] m25;
        x    = '0;
        x.sp = 1'b1;
        if (is_nan(a)) begin
            x.spv = F_QNAN;
        end else if (is_zero(a)) begin
            x.spv = a;
        end else if (a[31]) begin
            x.spv = F_QNAN;
        end else if (is_inf(a)) begin
            x.spv = a;
        end else begin
            x.sp = 1'b0;
            u    = unpack_norm(a);
            e    = u.e - 10'd150;
            if (!e[0]) begin
                m25 = {u.m, 1'b0};
                e   = e - 10'd1;
            end else begin
                m25 = {1'b0, u.m};
            end
            x.mw = {m25, 25'd0};
            t    = e - 10'd25;
            x.re = {t[9], t[9:1]} + 10'd151;
        end
        return x;
    endfunction

    // one root bit from the next two radicand bits
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t x);
        sqrt_lane_t y;
        logic [28:0] rem2;
        logic [28:0] t;
        logic        ge;
        y      = x;
        rem2   = {x.rem, x.mw[49:48]};
        t      = {2'b0, x.root, 2'b01};
        ge     = rem2 >= t;
        y.rem  = ge ? 27'(rem2 - t) : rem2[26:0];
        y.root = {x.root[23:0], ge};
        y.mw   = {x.mw[47:0], 2'b00};
        return y;
    endfunction

    function automatic logic [31:0] sqrt_final(input sqrt_lane_t x);
        logic inc;
        inc = x.root[0] & ((x.rem != 27'd0) | x.root[1]);
        return x.sp ? x.spv : ({1'b0, x.re[7:0], x.root[23:1]} + {31'd0, inc});
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pcrg_front.sv
`default_nettype none
// Camera-space direction, rotation and squared length: eight stages, one FP op deep each
module pcrg_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       pixel_u,
    input  wire logic [31:0]       pixel_v,
    input  wire pcrg_pkg::cfg_t    cfg,
    output logic                   out_valid,
    output pcrg_pkg::vec3_t        dir,
    output logic [31:0]            len2
);
    logic [7:0] v_reg;
    logic [31:0] t1_reg, t2_reg, lz1_reg;
    logic [31:0] lx_reg, ly_reg, lz2_reg;
    pcrg_pkg::vec3_t p0_reg, p1_reg, p2_reg;
    pcrg_pkg::vec3_t s4_reg, p2s4_reg;
    pcrg_pkg::vec3_t d5_reg;
    pcrg_pkg::vec3_t sq6_reg, d6_reg;
    logic [31:0] a7_reg, sq7_reg;
    pcrg_pkg::vec3_t d7_reg;
    logic [31:0] len2_reg;
    pcrg_pkg::vec3_t d8_reg;
    pcrg_pkg::vec3_t row0, row1, row2;

    // matrix rows, element [c] is column c
    assign row0 = {cfg.rot_m02_m10[31:0], cfg.rot_m00_m01[63:32], cfg.rot_m00_m01[31:0]};
    assign row1 = {cfg.rot_m11_m12[63:32], cfg.rot_m11_m12[31:0], cfg.rot_m02_m10[63:32]};
    assign row2 = {cfg.rot_m22, cfg.rot_m20_m21[63:32], cfg.rot_m20_m21[31:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // u-0.5, 1-v, 0.5*scale
            t1_reg  <= pcrg_pkg::fadd(pixel_u, pcrg_pkg::F_NHALF);
            t2_reg  <= pcrg_pkg::fadd(pcrg_pkg::F_ONE, {~pixel_v[31], pixel_v[30:0]});
            lz1_reg <= pcrg_pkg::fmul(pcrg_pkg::F_HALF, cfg.aspect_and_scale[63:32]);
            // camera-space x, y
            lx_reg  <= pcrg_pkg::fmul(t1_reg, cfg.aspect_and_scale[31:0]);
            ly_reg  <= pcrg_pkg::fadd(t2_reg, pcrg_pkg::F_NHALF);
            lz2_reg <= lz1_reg;
            // products, then sums left to right
            for (int c = 0; c < 3; c++) begin
                p0_reg[c]   <= pcrg_pkg::fmul(lx_reg, row0[c]);
                p1_reg[c]   <= pcrg_pkg::fmul(ly_reg, row1[c]);
                p2_reg[c]   <= pcrg_pkg::fmul(lz2_reg, row2[c]);
                s4_reg[c]   <= pcrg_pkg::fadd(p0_reg[c], p1_reg[c]);
                d5_reg[c]   <= pcrg_pkg::fadd(s4_reg[c], p2s4_reg[c]);
                sq6_reg[c]  <= pcrg_pkg::fmul(d5_reg[c], d5_reg[c]);
            end
            p2s4_reg <= p2_reg;
            d6_reg   <= d5_reg;
            a7_reg   <= pcrg_pkg::fadd(sq6_reg[0], sq6_reg[1]);
            sq7_reg  <= sq6_reg[2];
            d7_reg   <= d6_reg;
            len2_reg <= pcrg_pkg::fadd(a7_reg, sq7_reg);
            d8_reg   <= d7_reg;
        end
    end

    assign out_valid = v_reg[7];
    assign dir       = d8_reg;
    assign len2      = len2_reg;
endmodule
`default_nettype wire

// File: rtl/core/pcrg_sqrt.sv
`default_nettype none
// Pipelined square root, one root bit per stage; side vector travels alongside
module pcrg_sqrt (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       radicand,
    input  wire pcrg_pkg::vec3_t   side_in,
    output logic                   out_valid,
    output logic [31:0]            root,
    output pcrg_pkg::vec3_t        side_out
);
    localparam int NSTEP = pcrg_pkg::SQRT_STEPS;

    logic [NSTEP+1:0] v_reg;
    pcrg_pkg::sqrt_lane_t st_reg  [0:NSTEP];
    pcrg_pkg::sqrt_lane_t st_next [0:NSTEP];
    pcrg_pkg::vec3_t side_reg [0:NSTEP+1];
    logic [31:0] root_reg;

    always_comb begin
        st_next[0] = pcrg_pkg::sqrt_prep(radicand);
        for (int k = 0; k < NSTEP; k++) begin
            st_next[k+1] = pcrg_pkg::sqrt_step(st_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTEP:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= NSTEP; k++) begin
                st_reg[k] <= st_next[k];
            end
            side_reg[0] <= side_in;
            for (int k = 0; k <= NSTEP; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
            root_reg <= pcrg_pkg::sqrt_final(st_reg[NSTEP]);
        end
    end

    assign out_valid = v_reg[NSTEP+1];
    assign root      = root_reg;
    assign side_out  = side_reg[NSTEP+1];
endmodule
`default_nettype wire

// File: rtl/core/pcrg_div.sv
`default_nettype none
// Three-lane pipelined divider, one quotient bit per stage; operands travel alongside
module pcrg_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire pcrg_pkg::vec3_t   num,
    input  wire pcrg_pkg::vec3_t   den,
    output logic                   out_valid,
    output pcrg_pkg::vec3_t        quot,
    output pcrg_pkg::vec3_t        num_out,
    output pcrg_pkg::vec3_t        den_out
);
    localparam int NSTEP = pcrg_pkg::DIV_STEPS;

    logic [NSTEP+1:0] v_reg;
    pcrg_pkg::div_lane_t st_reg  [0:NSTEP][0:2];
    pcrg_pkg::div_lane_t st_next [0:NSTEP][0:2];
    pcrg_pkg::vec3_t num_reg [0:NSTEP+1];
    pcrg_pkg::vec3_t den_reg [0:NSTEP+1];
    pcrg_pkg::vec3_t quot_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            st_next[0][l] = pcrg_pkg::div_prep(num[l], den[l]);
            for (int k = 0; k < NSTEP; k++) begin
                st_next[k+1][l] = pcrg_pkg::div_step(st_reg[k][l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTEP:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= NSTEP; k++) begin
                for (int l = 0; l < 3; l++) begin
                    st_reg[k][l] <= st_next[k][l];
                end
            end
            num_reg[0] <= num;
            den_reg[0] <= den;
            for (int k = 0; k <= NSTEP; k++) begin
                num_reg[k+1] <= num_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
            for (int l = 0; l < 3; l++) begin
                quot_reg[l] <= pcrg_pkg::div_final(st_reg[NSTEP][l]);
            end
        end
    end

    assign out_valid = v_reg[NSTEP+1];
    assign quot      = quot_reg;
    assign num_out   = num_reg[NSTEP+1];
    assign den_out   = den_reg[NSTEP+1];
endmodule
`default_nettype wire

// File: rtl/core/pinhole_camera_ray_generation.sv
`default_nettype none
// Pinhole camera ray direction generator. Takes one pixel position (u,v) per clock as
// IEEE single-precision bits and returns the rotated, normalized ray direction and its
// per-component reciprocal, bit exact with round-to-nearest-even and subnormals kept.
// One item per clock unless m_tready stalls. The pipeline has 8 stages of add/multiply,
// 27 of square root, 27 of normalizing divide, 27 of reciprocal divide and the output
// register. The two dividers and the square root resolve one bit per stage, which sets
// the depth. A stall on m_tready freezes the whole pipeline. Configuration is taken
// on the cfg channel at any time and should only change while the block is idle.
module pinhole_camera_ray_generation (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,    // pixel_u, pixel_v
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [191:0]      m_tdata,    // dir_x, dir_y, dir_z, inv_x, inv_y, inv_z
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    pcrg_pkg::cfg_t cfg_reg;
    logic en;
    logic front_valid, sqrt_valid, div1_valid, div2_valid;
    pcrg_pkg::vec3_t front_dir, sqrt_dir, div1_q, div1_num, div1_den, dir, inv, dir_o;
    logic [31:0] len2, len;
    logic m_valid_reg;
    logic [191:0] m_data_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_m00_m01      <= 64'h000000003F800000;
            cfg_reg.rot_m02_m10      <= 64'd0;
            cfg_reg.rot_m11_m12      <= 64'h000000003F800000;
            cfg_reg.rot_m20_m21      <= 64'd0;
            cfg_reg.rot_m22          <= 32'h3F800000;
            cfg_reg.aspect_and_scale <= 64'h3F8000003F800000;
        end else if (cfg_valid) begin
            unique case (pcrg_pkg::cfg_reg_t'(cfg_index))
                pcrg_pkg::REG_ROT_M00_M01:      cfg_reg.rot_m00_m01      <= cfg_data;
                pcrg_pkg::REG_ROT_M02_M10:      cfg_reg.rot_m02_m10      <= cfg_data;
                pcrg_pkg::REG_ROT_M11_M12:      cfg_reg.rot_m11_m12      <= cfg_data;
                pcrg_pkg::REG_ROT_M20_M21:      cfg_reg.rot_m20_m21      <= cfg_data;
                pcrg_pkg::REG_ROT_M22:          cfg_reg.rot_m22          <= cfg_data[31:0];
                pcrg_pkg::REG_ASPECT_AND_SCALE: cfg_reg.aspect_and_scale <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a result is held at the output
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    pcrg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .pixel_u(s_tdata[31:0]), .pixel_v(s_tdata[63:32]), .cfg(cfg_reg),
        .out_valid(front_valid), .dir(front_dir), .len2(len2)
    );

    pcrg_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_valid),
        .radicand(len2), .side_in(front_dir),
        .out_valid(sqrt_valid), .root(len), .side_out(sqrt_dir)
    );

    pcrg_div u_norm (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sqrt_valid),
        .num(sqrt_dir), .den({len, len, len}),
        .out_valid(div1_valid), .quot(div1_q), .num_out(div1_num), .den_out(div1_den)
    );

    // zero length keeps the rotated vector as is
    assign dir = pcrg_pkg::is_zero(div1_den[0]) ? div1_num : div1_q;

    pcrg_div u_recip (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(div1_valid),
        .num({pcrg_pkg::F_ONE, pcrg_pkg::F_ONE, pcrg_pkg::F_ONE}), .den(dir),
        .out_valid(div2_valid), .quot(inv), .num_out(), .den_out(dir_o)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {pcrg_pkg::canon(inv[2]), pcrg_pkg::canon(inv[1]),
                           pcrg_pkg::canon(inv[0]), pcrg_pkg::canon(dir_o[2]),
                           pcrg_pkg::canon(dir_o[1]), pcrg_pkg::canon(dir_o[0])};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire

// File: rtl/core/pcrg_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the ray generator
module pcrg_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [191:0] m_tdata
);
    logic dir_x_ok;
    logic inv_x_ok;

    // a NaN on dir_x or inv_x must be the canonical one
    assign dir_x_ok = (m_tdata[30:23] != 8'hFF) || (m_tdata[22:0] == 23'd0)
                      || (m_tdata[31:0] == 32'h7FC00000);
    assign inv_x_ok = (m_tdata[126:119] != 8'hFF) || (m_tdata[118:96] == 23'd0)
                      || (m_tdata[127:96] == 32'h7FC00000);

    // held result keeps its value
    `ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
    // input side is open whenever nothing waits at the output
    `ASSERT_CLK(a_ready, !m_tvalid |-> s_tready, "input stalled with empty output")
    // reset empties the output
    `ASSERT_ALWAYS(a_rst, !aresetn |=> !m_tvalid, "result after reset")
    // only the canonical NaN leaves the block
    `ASSERT_CLK(a_nan_dir, m_tvalid |-> dir_x_ok, "non-canonical NaN on dir_x")
    `ASSERT_CLK(a_nan_inv, m_tvalid |-> inv_x_ok, "non-canonical NaN on inv_x")
endmodule

bind pinhole_camera_ray_generation pcrg_checker u_pcrg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
